>>> rtl/x86enc_pkg.sv
// ----------------------------------------------------------------------------
// x86enc_pkg
// Shared types, codes and helpers for the x86-64 instruction byte encoder.
// ----------------------------------------------------------------------------
package x86enc_pkg;

    // Register and operand codes
    localparam logic [4:0] REG_NONE     = 5'd16;
    localparam logic [4:0] CC_NONE      = 5'd16;
    localparam logic [3:0] EXT_REG      = 4'd8;
    localparam logic [3:0] EXT_RADD     = 4'd9;
    localparam logic [3:0] EXT_NONE     = 4'd10;
    localparam logic [1:0] RM_NONE      = 2'd0;
    localparam logic [1:0] RM_REG       = 2'd1;
    localparam logic [1:0] RM_MEM       = 2'd2;
    localparam logic [1:0] RM_RIP       = 2'd3;

    // Fixed encoding bytes and fields
    localparam logic [7:0] REX_BASE     = 8'h40;
    localparam logic [7:0] REX_R        = 8'h44;
    localparam logic [7:0] REX_X        = 8'h42;
    localparam logic [7:0] REX_B        = 8'h41;
    localparam logic [7:0] SIB_NO_INDEX = 8'b0010_0100;
    localparam logic [2:0] RM_SIB       = 3'b100;
    localparam logic [2:0] RM_DISP32    = 3'b101;
    localparam logic [1:0] MOD_NODISP   = 2'b00;
    localparam logic [1:0] MOD_DISP8    = 2'b01;
    localparam logic [1:0] MOD_DISP32   = 2'b10;
    localparam logic [1:0] MOD_REG      = 2'b11;

    // Byte slot layout of one instruction
    localparam int SLOTS     = 20;
    localparam int SLOT_PFX  = 0;
    localparam int SLOT_REX  = 1;
    localparam int SLOT_OPC  = 2;
    localparam int SLOT_MODRM = 6;
    localparam int SLOT_SIB  = 7;
    localparam int SLOT_DISP = 8;
    localparam int SLOT_IMM  = 12;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Normalized instruction captured by the front input stage
    typedef struct packed {
        logic [7:0]  prefix;
        logic [7:0]  rex;
        logic [31:0] opc;
        logic [3:0]  ext;
        logic [1:0]  rmkind;
        logic [3:0]  nimm;
        logic [63:0] imm;
        logic [4:0]  rreg;
        logic [4:0]  base;
        logic [4:0]  index;
        logic [1:0]  scale;
        logic [31:0] disp;
    } x86enc_insn_t;

    // Fully laid out instruction: byte slots and which of them are emitted
    typedef struct packed {
        logic [SLOTS-1:0]      mask;
        logic [SLOTS-1:0][7:0] bytes;
    } x86enc_desc_t;

    // Immediate size code to byte count
    function automatic logic [3:0] imm_bytes(input logic [2:0] code);
        logic [3:0] n;
        case (code)
            3'd0:    n = 4'd0;
            3'd1:    n = 4'd1;
            3'd2:    n = 4'd2;
            3'd3:    n = 4'd4;
            3'd4:    n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // Register codes above sixteen mean no register
    function automatic logic [4:0] norm_reg(input logic [4:0] r);
        return (r > REG_NONE) ? REG_NONE : r;
    endfunction

endpackage

>>> rtl/x86enc_front.sv
// ----------------------------------------------------------------------------
// x86enc_front
// Accepts instruction templates, normalizes them in an input register and
// lays out the byte slots of the encoded instruction for the queue.
// ----------------------------------------------------------------------------
module x86enc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [15:0]                 prefix_and_rex,
    input  logic [31:0]                 opcode_word,
    input  logic [3:0]                  ext_code,
    input  logic [4:0]                  cond_code,
    input  logic [6:0]                  operand_kinds,
    input  logic [63:0]                 immediate_value,
    input  logic [4:0]                  reg_operand,
    input  logic [4:0]                  base_register,
    input  logic [4:0]                  index_register,
    input  logic [1:0]                  scale_log2,
    input  logic signed [31:0]          displacement,
    output logic                        push_valid,
    input  logic                        push_ready,
    output x86enc_pkg::x86enc_desc_t    push_desc
);

    logic                     a_valid_reg;
    logic                     a_valid_next;
    x86enc_pkg::x86enc_insn_t a_reg;
    x86enc_pkg::x86enc_insn_t a_next;
    logic                     a_adv;
    logic                     desc_empty;

    // Input normalization: opcode add, reg replacement, REX bits
    always_comb
    begin
        logic [3:0] ext_n;
        logic [4:0] rreg_n;
        logic [4:0] base_n;
        logic [4:0] index_n;
        logic [3:0] cc_add;
        logic [2:0] radd;
        logic [4:0] small_add;
        logic [4:0] rreg_e;
        logic [7:0] rex;
        logic [1:0] rmkind;
        ext_n   = (ext_code > x86enc_pkg::EXT_NONE) ? x86enc_pkg::EXT_NONE : ext_code;
        rreg_n  = x86enc_pkg::norm_reg(reg_operand);
        base_n  = x86enc_pkg::norm_reg(base_register);
        index_n = x86enc_pkg::norm_reg(index_register);
        rmkind  = operand_kinds[1:0];
        cc_add  = (cond_code < x86enc_pkg::CC_NONE) ? cond_code[3:0] : 4'd0;
        radd    = (ext_n == x86enc_pkg::EXT_RADD) ? base_n[2:0] : 3'd0;
        small_add = {1'b0, cc_add} + {2'b00, radd};
        rreg_e  = (ext_n < x86enc_pkg::EXT_REG) ? {1'b0, ext_n} : rreg_n;

        rex = prefix_and_rex[7:0];
        if (rreg_e[3])
        begin
            rex = rex | x86enc_pkg::REX_R;
        end
        if (base_n[3])
        begin
            rex = rex | x86enc_pkg::REX_B;
        end
        if (index_n[3])
        begin
            rex = rex | x86enc_pkg::REX_X;
        end
        // SPL/BPL/SIL/DIL need an empty REX
        if (rex == 8'h00)
        begin
            if ((ext_n == x86enc_pkg::EXT_REG && rreg_e[4:2] == 3'b001 && operand_kinds[5])
                || (rmkind == x86enc_pkg::RM_REG && base_n[4:2] == 3'b001
                    && operand_kinds[6]))
            begin
                rex = x86enc_pkg::REX_BASE;
            end
        end

        a_next.prefix = prefix_and_rex[15:8];
        a_next.rex    = rex;
        a_next.opc    = opcode_word + {27'd0, small_add};
        a_next.ext    = ext_n;
        a_next.rmkind = rmkind;
        a_next.nimm   = x86enc_pkg::imm_bytes(operand_kinds[4:2]);
        a_next.imm    = immediate_value;
        a_next.rreg   = rreg_e;
        a_next.base   = base_n;
        a_next.index  = index_n;
        a_next.scale  = scale_log2;
        a_next.disp   = displacement;
    end

    // Slot layout from the input register
    always_comb
    begin
        logic       has_modrm;
        logic       disp_s8;
        logic [2:0] opc_cnt;
        logic [4:0] delta;
        logic [31:0] dval;
        logic [2:0] dbytes;
        logic [1:0] modf;
        logic [2:0] rmf;
        push_desc = '0;
        opc_cnt   = 3'd0;
        dval      = a_reg.disp;
        dbytes    = 3'd0;
        modf      = x86enc_pkg::MOD_NODISP;
        rmf       = a_reg.base[2:0];

        if (a_reg.prefix != 8'h00)
        begin
            push_desc.mask[x86enc_pkg::SLOT_PFX]  = 1'b1;
            push_desc.bytes[x86enc_pkg::SLOT_PFX] = a_reg.prefix;
        end
        if (a_reg.rex != 8'h00)
        begin
            push_desc.mask[x86enc_pkg::SLOT_REX]  = 1'b1;
            push_desc.bytes[x86enc_pkg::SLOT_REX] = a_reg.rex;
        end
        // opcode bytes, most significant first, zero bytes skipped
        for (int k = 0; k < 4; k++)
        begin
            push_desc.bytes[x86enc_pkg::SLOT_OPC + k] = a_reg.opc[31 - 8*k -: 8];
            if (a_reg.opc[31 - 8*k -: 8] != 8'h00)
            begin
                push_desc.mask[x86enc_pkg::SLOT_OPC + k] = 1'b1;
                opc_cnt = opc_cnt + 3'd1;
            end
        end

        has_modrm = (a_reg.ext != x86enc_pkg::EXT_NONE)
                    && (a_reg.rmkind != x86enc_pkg::RM_NONE);
        disp_s8   = (&a_reg.disp[31:7]) || !(|a_reg.disp[31:7]);
        // bytes up to and including ModRM, disp32, immediate
        delta = {4'd0, (a_reg.prefix != 8'h00)} + {4'd0, (a_reg.rex != 8'h00)}
                + {2'd0, opc_cnt} + 5'd5 + {1'b0, a_reg.nimm};

        if (has_modrm)
        begin
            push_desc.mask[x86enc_pkg::SLOT_MODRM] = 1'b1;
            case (a_reg.rmkind)
                x86enc_pkg::RM_REG:
                begin
                    modf = x86enc_pkg::MOD_REG;
                end
                x86enc_pkg::RM_RIP:
                begin
                    rmf    = x86enc_pkg::RM_DISP32;
                    dval   = a_reg.disp - {27'd0, delta};
                    dbytes = 3'd4;
                end
                default:
                begin
                    if (a_reg.disp == 32'd0)
                    begin
                        // base 101 cannot go without displacement
                        if (a_reg.base[2:0] == x86enc_pkg::RM_DISP32)
                        begin
                            modf   = x86enc_pkg::MOD_DISP8;
                            dbytes = 3'd1;
                        end
                    end
                    else if (disp_s8)
                    begin
                        modf   = x86enc_pkg::MOD_DISP8;
                        dbytes = 3'd1;
                    end
                    else
                    begin
                        modf   = x86enc_pkg::MOD_DISP32;
                        dbytes = 3'd4;
                    end
                    if (a_reg.index == x86enc_pkg::REG_NONE)
                    begin
                        if (a_reg.base[2:0] == x86enc_pkg::RM_SIB)
                        begin
                            push_desc.mask[x86enc_pkg::SLOT_SIB]  = 1'b1;
                            push_desc.bytes[x86enc_pkg::SLOT_SIB] = x86enc_pkg::SIB_NO_INDEX;
                        end
                    end
                    else
                    begin
                        rmf = x86enc_pkg::RM_SIB;
                        push_desc.mask[x86enc_pkg::SLOT_SIB]  = 1'b1;
                        push_desc.bytes[x86enc_pkg::SLOT_SIB] =
                            {a_reg.scale, a_reg.index[2:0], a_reg.base[2:0]};
                    end
                end
            endcase
            push_desc.bytes[x86enc_pkg::SLOT_MODRM] = {modf, a_reg.rreg[2:0], rmf};
        end

        // displacement, little-endian
        for (int k = 0; k < 4; k++)
        begin
            push_desc.bytes[x86enc_pkg::SLOT_DISP + k] = dval[8*k +: 8];
            push_desc.mask[x86enc_pkg::SLOT_DISP + k]  = (k < int'(dbytes));
        end
        // immediate, little-endian
        for (int k = 0; k < 8; k++)
        begin
            push_desc.bytes[x86enc_pkg::SLOT_IMM + k] = a_reg.imm[8*k +: 8];
            push_desc.mask[x86enc_pkg::SLOT_IMM + k]  = (k < int'(a_reg.nimm));
        end
    end

    // Handshake: an item with nothing to emit is dropped here
    assign desc_empty   = (push_desc.mask == '0);
    assign push_valid   = a_valid_reg && !desc_empty;
    assign a_adv        = a_valid_reg && (push_ready || desc_empty);
    assign item_ready   = !a_valid_reg || a_adv;
    assign a_valid_next = item_valid || (a_valid_reg && !a_adv);

    // Input stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            a_reg <= a_next;
        end
    end

endmodule

>>> rtl/x86enc_queue.sv
// ----------------------------------------------------------------------------
// x86enc_queue
// Short FIFO of laid-out instructions between front and back.
// ----------------------------------------------------------------------------
module x86enc_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push_valid,
    output logic                        push_ready,
    input  x86enc_pkg::x86enc_desc_t    push_desc,
    output logic                        pop_valid,
    input  logic                        pop_ready,
    output x86enc_pkg::x86enc_desc_t    pop_desc
);

    x86enc_pkg::x86enc_desc_t               entry_reg [x86enc_pkg::QDEPTH];
    logic [x86enc_pkg::QPTR_W-1:0]          wr_ptr_reg;
    logic [x86enc_pkg::QPTR_W-1:0]          wr_ptr_next;
    logic [x86enc_pkg::QPTR_W-1:0]          rd_ptr_reg;
    logic [x86enc_pkg::QPTR_W-1:0]          rd_ptr_next;
    logic [x86enc_pkg::QCNT_W-1:0]          count_reg;
    logic [x86enc_pkg::QCNT_W-1:0]          count_next;
    logic                                   push;
    logic                                   pop;

    assign push_ready = (count_reg != x86enc_pkg::QCNT_W'(x86enc_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == x86enc_pkg::QPTR_W'(x86enc_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == x86enc_pkg::QPTR_W'(x86enc_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

>>> rtl/x86enc_back.sv
// ----------------------------------------------------------------------------
// x86enc_back
// Serializes one laid-out instruction into a registered output, a byte per
// cycle unless stalled, lowest used slot first, and marks the final byte.
// ----------------------------------------------------------------------------
module x86enc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  x86enc_pkg::x86enc_desc_t    pop_desc,
    output logic                        code_valid,
    input  logic                        code_ready,
    output logic [7:0]                  code_byte,
    output logic                        last_byte
);

    logic [x86enc_pkg::SLOTS-1:0]       mask_reg;
    logic [x86enc_pkg::SLOTS-1:0]       mask_next;
    logic [x86enc_pkg::SLOTS-1:0][7:0]  bytes_reg;
    logic [x86enc_pkg::SLOTS-1:0]       lsb;
    logic [x86enc_pkg::SLOTS-1:0]       rest;
    logic [7:0]                         sel_byte;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [7:0]                         code_byte_reg;
    logic                               last_byte_reg;
    logic                               out_free;
    logic                               emit;
    logic                               load;

    // Pick the lowest pending slot
    assign lsb  = mask_reg & (~mask_reg + 1'b1);
    assign rest = mask_reg & ~lsb;

    always_comb
    begin
        sel_byte = 8'h00;
        for (int k = 0; k < x86enc_pkg::SLOTS; k++)
        begin
            sel_byte = sel_byte | (bytes_reg[k] & {8{lsb[k]}});
        end
    end

    // Emit when the output register is free; refill on the final byte
    assign out_free  = !out_valid_reg || code_ready;
    assign emit      = out_free && (mask_reg != '0);
    assign pop_ready = (mask_reg == '0) || (emit && rest == '0);
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = pop_desc.mask;
        end
        else if (emit)
        begin
            mask_next = rest;
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (code_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= pop_desc.bytes;
        end
        if (emit)
        begin
            code_byte_reg <= sel_byte;
            last_byte_reg <= (rest == '0);
        end
    end

    assign code_valid = out_valid_reg;
    assign code_byte  = code_byte_reg;
    assign last_byte  = last_byte_reg;

endmodule

>>> rtl/x86_64_instruction_byte_encoder.sv
// ----------------------------------------------------------------------------
// x86_64_instruction_byte_encoder
// Encodes instruction templates into x86-64 machine code, one byte a transfer.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready) takes one instruction template per
//   transfer; the code channel (code_valid/code_ready) returns its bytes in
//   order, prefix, REX, opcode, ModRM, SIB, displacement, immediate, with
//   last_byte set on the final one. A template that encodes to nothing
//   produces no transfer on the code channel.
//   Path: input register, queue entry, serializer slots, output register.
//   Throughput: one code byte per cycle unless stalled; an instruction of N
//   bytes (1..20) takes N transfers. The front stage takes a new item every
//   cycle while the two-entry queue in front of the serializer has room, so
//   item intake stalls only once two laid-out instructions wait there.
//   When code_ready is low the output register holds its byte, the serializer
//   stops, then the queue fills and item_ready drops.
//   Reset (rst_n low, asynchronous) empties the input stage, queue and
//   output; the block is ready for an item as soon as reset is released.
// ----------------------------------------------------------------------------
module x86_64_instruction_byte_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [15:0]        prefix_and_rex,
    input  logic [31:0]        opcode_word,
    input  logic [3:0]         ext_code,
    input  logic [4:0]         cond_code,
    input  logic [6:0]         operand_kinds,
    input  logic [63:0]        immediate_value,
    input  logic [4:0]         reg_operand,
    input  logic [4:0]         base_register,
    input  logic [4:0]         index_register,
    input  logic [1:0]         scale_log2,
    input  logic signed [31:0] displacement,
    output logic               code_valid,
    input  logic               code_ready,
    output logic [7:0]         code_byte,
    output logic               last_byte
);

    logic                     push_valid;
    logic                     push_ready;
    x86enc_pkg::x86enc_desc_t push_desc;
    logic                     pop_valid;
    logic                     pop_ready;
    x86enc_pkg::x86enc_desc_t pop_desc;

    // Front: accept and lay out
    x86enc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .prefix_and_rex  (prefix_and_rex),
        .opcode_word     (opcode_word),
        .ext_code        (ext_code),
        .cond_code       (cond_code),
        .operand_kinds   (operand_kinds),
        .immediate_value (immediate_value),
        .reg_operand     (reg_operand),
        .base_register   (base_register),
        .index_register  (index_register),
        .scale_log2      (scale_log2),
        .displacement    (displacement),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_desc       (push_desc)
    );

    // Decoupling queue
    x86enc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    // Back: byte serializer
    x86enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_byte  (code_byte),
        .last_byte  (last_byte)
    );

endmodule

>>> rtl/x86enc_checker.sv
// ----------------------------------------------------------------------------
// x86enc_checker
// Port-level checks on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module x86enc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_ready,
    input  logic       code_valid,
    input  logic       code_ready,
    input  logic [7:0] code_byte,
    input  logic       last_byte
);

    logic [4:0] byte_cnt_reg;
    logic [4:0] byte_cnt_next;
    logic       code_xfer;

    assign code_xfer = code_valid && code_ready;

    // Bytes sent so far in the current instruction
    always_comb
    begin
        byte_cnt_next = byte_cnt_reg;
        if (code_xfer)
        begin
            byte_cnt_next = last_byte ? 5'd0 : byte_cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= 5'd0;
        end
        else
        begin
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    // A stalled byte holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_ready |=> code_valid && $stable(code_byte)
                                      && $stable(last_byte))
        else $error("code byte changed while stalled");

    // No instruction runs past twenty bytes
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        code_xfer && !last_byte |-> byte_cnt_reg < 5'd19)
        else $error("instruction longer than twenty bytes");

    // Output is quiet right after reset
    a_rst: assert property (@(posedge clk)
        $rose(rst_n) |-> !code_valid)
        else $error("code output valid right after reset");

    // A first byte needs an earlier item transfer, a stall or code activity
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(code_valid) && byte_cnt_reg == 5'd0 |->
            $past(item_valid && item_ready, 3) || $past(code_valid, 1)
            || $past(!item_ready, 3) || $past(code_valid, 2) || $past(code_valid, 3)
            || $past(item_valid && item_ready, 4) || $past(item_valid, 5))
        else $error("code byte without a preceding item");

endmodule

bind x86_64_instruction_byte_encoder x86enc_checker u_x86enc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code_byte  (code_byte),
    .last_byte  (last_byte)
);

>>> bench/tb_x86_64_instruction_byte_encoder.sv
// ----------------------------------------------------------------------------
// tb_x86_64_instruction_byte_encoder
// Self-checking bench for the x86-64 instruction byte encoder. Templates go
// in on the item channel. Each accepted template is encoded by a local model
// into its expected byte stream. Every code byte transfer is checked, value
// and last flag, against the oldest expected byte. The directed templates
// hit the encoding corners. The random ones are mostly realistic
// instructions with some raw noise mixed in. Both channels idle at random,
// except in one burst window where neither side idles.
// ----------------------------------------------------------------------------
module tb_x86_64_instruction_byte_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 370;
    localparam int unsigned BURST_LO     = 1200;
    localparam int unsigned BURST_HI     = 2000;
    localparam int          IDLE_PCT     = 38;
    localparam int          DRAIN_CYCLES = 20;

    // One instruction template, as it appears on the item ports
    typedef struct packed {
        logic [15:0] prefix_and_rex;
        logic [31:0] opcode_word;
        logic [3:0]  ext_code;
        logic [4:0]  cond_code;
        logic [6:0]  operand_kinds;
        logic [63:0] immediate_value;
        logic [4:0]  reg_operand;
        logic [4:0]  base_register;
        logic [4:0]  index_register;
        logic [1:0]  scale_log2;
        logic [31:0] displacement;
    } insn_t;

    typedef logic [7:0] code_q_t[$];

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } code_exp_t;

    // ------------------------------------------------------------------------
    // Scoreboard: encodes accepted templates, checks emitted code bytes
    // ------------------------------------------------------------------------
    class code_scoreboard;
        code_exp_t   pending_q[$];
        int unsigned errors;
        int unsigned byte_cnt;

        static function logic [4:0] clamp_reg(logic [4:0] r);
            return (r > x86enc_pkg::REG_NONE) ? x86enc_pkg::REG_NONE : r;
        endfunction

        static function logic [3:0] imm_len(logic [2:0] code);
            logic [3:0] n;
            case (code)
                3'd1:    n = 4'd1;
                3'd2:    n = 4'd2;
                3'd3:    n = 4'd4;
                3'd4:    n = 4'd8;
                default: n = 4'd0;
            endcase
            return n;
        endfunction

        // Expected machine code of one template
        static function code_q_t encode_insn(insn_t t);
            logic [7:0]  prefix;
            logic [7:0]  rex;
            logic [31:0] opc;
            logic [31:0] disp;
            logic [31:0] rel;
            logic [3:0]  ext;
            logic [3:0]  nimm;
            logic [3:0]  dbytes;
            logic [4:0]  rreg;
            logic [4:0]  base;
            logic [4:0]  index;
            logic [1:0]  rmkind;
            logic [1:0]  b8;
            logic [1:0]  mod;
            code_q_t     q;
            int          n;

            prefix = t.prefix_and_rex[15:8];
            rex    = t.prefix_and_rex[7:0];
            opc    = t.opcode_word;
            ext    = (t.ext_code > x86enc_pkg::EXT_NONE) ? x86enc_pkg::EXT_NONE
                                                         : t.ext_code;
            rreg   = clamp_reg(t.reg_operand);
            base   = clamp_reg(t.base_register);
            index  = clamp_reg(t.index_register);
            disp   = t.displacement;
            rmkind = t.operand_kinds[1:0];
            nimm   = imm_len(t.operand_kinds[4:2]);
            b8     = t.operand_kinds[6:5];

            if (prefix != 8'h00)
                q.push_back(prefix);

            // condition code, register-add or digit extension
            if (t.cond_code < x86enc_pkg::CC_NONE)
                opc = opc + 32'(t.cond_code);
            if (ext == x86enc_pkg::EXT_RADD)
                opc = opc + 32'(base[2:0]);
            else if (ext < x86enc_pkg::EXT_REG)
                rreg = {1'b0, ext};

            // REX extension bits, then forced REX for SPL/BPL/SIL/DIL
            if (rreg[3])
                rex = rex | x86enc_pkg::REX_R;
            if (base[3])
                rex = rex | x86enc_pkg::REX_B;
            if (index[3])
                rex = rex | x86enc_pkg::REX_X;
            if (rex == 8'h00)
            begin
                if (ext == x86enc_pkg::EXT_REG && rreg[4:2] == 3'b001 && b8[0])
                    rex = x86enc_pkg::REX_BASE;
                else if (rmkind == x86enc_pkg::RM_REG && base[4:2] == 3'b001 && b8[1])
                    rex = x86enc_pkg::REX_BASE;
            end
            if (rex != 8'h00)
                q.push_back(rex);

            for (n = 3; n >= 0; n--)
            begin
                if (opc[8*n +: 8] != 8'h00)
                    q.push_back(opc[8*n +: 8]);
            end

            // ModRM, SIB and displacement
            if (ext != x86enc_pkg::EXT_NONE && rmkind != x86enc_pkg::RM_NONE)
            begin
                if (rmkind == x86enc_pkg::RM_REG)
                begin
                    q.push_back({x86enc_pkg::MOD_REG, rreg[2:0], base[2:0]});
                end
                else if (rmkind == x86enc_pkg::RM_RIP)
                begin
                    q.push_back({x86enc_pkg::MOD_NODISP, rreg[2:0], x86enc_pkg::RM_DISP32});
                    rel = disp - (32'(q.size()) + 32'd4 + 32'(nimm));
                    for (n = 0; n < 4; n++)
                        q.push_back(rel[8*n +: 8]);
                end
                else
                begin
                    if (disp == 32'd0)
                    begin
                        mod    = (base[2:0] == x86enc_pkg::RM_DISP32) ? x86enc_pkg::MOD_DISP8
                                                                      : x86enc_pkg::MOD_NODISP;
                        dbytes = (base[2:0] == x86enc_pkg::RM_DISP32) ? 4'd1 : 4'd0;
                    end
                    else if ((disp + 32'd128) < 32'd256)
                    begin
                        mod    = x86enc_pkg::MOD_DISP8;
                        dbytes = 4'd1;
                    end
                    else
                    begin
                        mod    = x86enc_pkg::MOD_DISP32;
                        dbytes = 4'd4;
                    end
                    if (index == x86enc_pkg::REG_NONE)
                    begin
                        q.push_back({mod, rreg[2:0], base[2:0]});
                        if (base[2:0] == x86enc_pkg::RM_SIB)
                            q.push_back(x86enc_pkg::SIB_NO_INDEX);
                    end
                    else
                    begin
                        q.push_back({mod, rreg[2:0], x86enc_pkg::RM_SIB});
                        q.push_back({t.scale_log2, index[2:0], base[2:0]});
                    end
                    for (n = 0; n < int'(dbytes); n++)
                        q.push_back(disp[8*n +: 8]);
                end
            end

            for (n = 0; n < int'(nimm); n++)
                q.push_back(t.immediate_value[8*n +: 8]);
            return q;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task note_insn(insn_t t);
            code_q_t bytes;
            bytes = encode_insn(t);
            foreach (bytes[i])
                pending_q.push_back({bytes[i], i == bytes.size() - 1});
        endtask

        task check_byte(logic [7:0] value, logic last);
            code_exp_t e;
            if (pending_q.size() == 0)
            begin
                report($sformatf("byte %0d = %02h (last %b) with nothing outstanding",
                                 byte_cnt, value, last));
            end
            else
            begin
                e = pending_q.pop_front();
                if (value !== e.value)
                    report($sformatf("byte %0d code_byte %02h, want %02h",
                                     byte_cnt, value, e.value));
                if (last !== e.last)
                    report($sformatf("byte %0d last_byte %b, want %b",
                                     byte_cnt, last, e.last));
            end
            byte_cnt++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        item_valid      = 1'b0;
    logic        item_ready;
    logic [15:0] prefix_and_rex  = '0;
    logic [31:0] opcode_word     = '0;
    logic [3:0]  ext_code        = '0;
    logic [4:0]  cond_code       = '0;
    logic [6:0]  operand_kinds   = '0;
    logic [63:0] immediate_value = '0;
    logic [4:0]  reg_operand     = '0;
    logic [4:0]  base_register   = '0;
    logic [4:0]  index_register  = '0;
    logic [1:0]  scale_log2      = '0;
    logic signed [31:0] displacement = '0;
    logic        code_valid;
    logic        code_ready      = 1'b0;
    logic [7:0]  code_byte;
    logic        last_byte;

    int unsigned    cyc = 0;
    code_scoreboard sb  = new();
    insn_t          stim_q[$];

    x86_64_instruction_byte_encoder u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .prefix_and_rex  (prefix_and_rex),
        .opcode_word     (opcode_word),
        .ext_code        (ext_code),
        .cond_code       (cond_code),
        .operand_kinds   (operand_kinds),
        .immediate_value (immediate_value),
        .reg_operand     (reg_operand),
        .base_register   (base_register),
        .index_register  (index_register),
        .scale_log2      (scale_log2),
        .displacement    (displacement),
        .code_valid      (code_valid),
        .code_ready      (code_ready),
        .code_byte       (code_byte),
        .last_byte       (last_byte)
    );

    // Clock and reset
    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
        cyc <= cyc + 1;

    // No idling on either side inside the burst window
    function automatic bit keep_busy();
        return cyc >= BURST_LO && cyc < BURST_HI;
    endfunction

    // ------------------------------------------------------------------------
    // Template builders
    // ------------------------------------------------------------------------
    function automatic logic [6:0] kinds_of(logic [1:0] b8, logic [2:0] immc,
                                            logic [1:0] rm);
        return {b8, immc, rm};
    endfunction

    function automatic insn_t insn(logic [15:0] pr, logic [31:0] opc, logic [3:0] ext,
                                   logic [4:0] cc, logic [6:0] kinds, logic [63:0] imm,
                                   logic [4:0] rr, logic [4:0] rb, logic [4:0] ri,
                                   logic [1:0] sc, logic [31:0] disp);
        insn_t t;
        t.prefix_and_rex  = pr;
        t.opcode_word     = opc;
        t.ext_code        = ext;
        t.cond_code       = cc;
        t.operand_kinds   = kinds;
        t.immediate_value = imm;
        t.reg_operand     = rr;
        t.base_register   = rb;
        t.index_register  = ri;
        t.scale_log2      = sc;
        t.displacement    = disp;
        return t;
    endfunction

    // Mostly realistic templates, about one in five raw noise
    function automatic insn_t rand_insn();
        insn_t      t;
        logic [7:0] pfx;
        logic [7:0] rex;
        logic [7:0] op8;

        if ($urandom_range(99) < 20)
        begin
            t.prefix_and_rex  = 16'($urandom);
            t.opcode_word     = $urandom;
            t.ext_code        = 4'($urandom);
            t.cond_code       = 5'($urandom);
            t.operand_kinds   = 7'($urandom);
            t.immediate_value = {$urandom, $urandom};
            t.reg_operand     = 5'($urandom);
            t.base_register   = 5'($urandom);
            t.index_register  = 5'($urandom);
            t.scale_log2      = 2'($urandom);
            t.displacement    = $urandom;
            return t;
        end

        case ($urandom_range(7))
            0:       pfx = 8'h66;
            1:       pfx = 8'hF2;
            2:       pfx = 8'hF3;
            3:       pfx = 8'h67;
            default: pfx = 8'h00;
        endcase
        case ($urandom_range(5))
            0:       rex = 8'h48;
            1:       rex = x86enc_pkg::REX_BASE;
            2:       rex = x86enc_pkg::REX_BASE | 8'($urandom_range(15));
            default: rex = 8'h00;
        endcase
        op8 = 8'($urandom);
        case ($urandom_range(3))
            0:       t.opcode_word = {16'h0000, 8'h0F, op8};
            1:       t.opcode_word = {8'h00, 16'h0F38, op8};
            default: t.opcode_word = {24'h0, op8};
        endcase
        t.prefix_and_rex  = {pfx, rex};
        t.ext_code        = 4'($urandom_range(10));
        t.cond_code       = ($urandom_range(3) == 0) ? 5'($urandom_range(15))
                                                     : x86enc_pkg::CC_NONE;
        t.operand_kinds   = kinds_of(2'($urandom), 3'($urandom_range(4)),
                                     2'($urandom));
        t.immediate_value = {$urandom, $urandom};
        t.reg_operand     = 5'($urandom_range(16));
        t.base_register   = 5'($urandom_range(16));
        t.index_register  = ($urandom_range(1) == 0) ? x86enc_pkg::REG_NONE
                                                     : 5'($urandom_range(15));
        t.scale_log2      = 2'($urandom);
        case ($urandom_range(4))
            0:       t.displacement = 32'd0;
            1:       t.displacement = 32'($urandom_range(255)) - 32'd128;
            2:       t.displacement = {24'h0, 8'($urandom)};
            3:       t.displacement = {24'hFF_FFFF, 8'($urandom)};
            default: t.displacement = $urandom;
        endcase
        return t;
    endfunction

    task build_directed();
        // nothing to emit, then every field at its maximum
        stim_q.push_back(insn(16'h0, 32'h0, 4'd0, 5'd0, 7'd0, 64'h0, 5'd0, 5'd0, 5'd0,
                              2'd0, 32'h0));
        stim_q.push_back(insn(16'hFFFF, 32'hFFFF_FFFF, 4'hF, 5'h1F, 7'h7F, '1, 5'h1F,
                              5'h1F, 5'h1F, 2'd3, 32'hFFFF_FFFF));
        // register forms, forced REX for byte registers
        stim_q.push_back(insn(16'h0048, 32'h89, x86enc_pkg::EXT_REG, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_REG), 64'h0, 5'd3, 5'd12,
                              x86enc_pkg::REG_NONE, 2'd0, 32'h0));
        stim_q.push_back(insn(16'h0, 32'h88, x86enc_pkg::EXT_REG, x86enc_pkg::CC_NONE,
                              kinds_of(2'b01, 3'd0, x86enc_pkg::RM_REG), 64'h0, 5'd6, 5'd1,
                              x86enc_pkg::REG_NONE, 2'd0, 32'h0));
        stim_q.push_back(insn(16'h0, 32'hF6, 4'd3, x86enc_pkg::CC_NONE,
                              kinds_of(2'b10, 3'd0, x86enc_pkg::RM_REG), 64'h0,
                              x86enc_pkg::REG_NONE, 5'd7, x86enc_pkg::REG_NONE, 2'd0, 32'h0));
        // base 101 with zero displacement
        stim_q.push_back(insn(16'h0, 32'hFF, 4'd6, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_MEM), 64'h0,
                              x86enc_pkg::REG_NONE, 5'd5, x86enc_pkg::REG_NONE, 2'd0, 32'h0));
        stim_q.push_back(insn(16'h0048, 32'hC7, 4'd0, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd3, x86enc_pkg::RM_MEM), 64'h1234_5678,
                              x86enc_pkg::REG_NONE, 5'd13, x86enc_pkg::REG_NONE, 2'd0, 32'h0));
        // base 100 without index
        stim_q.push_back(insn(16'h0, 32'h8B, x86enc_pkg::EXT_REG, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_MEM), 64'h0, 5'd0, 5'd4,
                              x86enc_pkg::REG_NONE, 2'd0, 32'd8));
        stim_q.push_back(insn(16'h0, 32'h8B, x86enc_pkg::EXT_REG, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_MEM), 64'h0, 5'd14, 5'd12,
                              x86enc_pkg::REG_NONE, 2'd0, 32'h0));
        // stack pointer as index, then disp8/disp32 boundaries
        stim_q.push_back(insn(16'h0, 32'h8D, x86enc_pkg::EXT_REG, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_MEM), 64'h0, 5'd2, 5'd3,
                              5'd4, 2'd2, 32'd127));
        stim_q.push_back(insn(16'h0, 32'h8D, x86enc_pkg::EXT_REG, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_MEM), 64'h0, 5'd1, 5'd0,
                              5'd9, 2'd3, 32'hFFFF_FF80));
        stim_q.push_back(insn(16'h0, 32'h8D, x86enc_pkg::EXT_REG, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_MEM), 64'h0, 5'd7, 5'd8,
                              5'd15, 2'd1, 32'd128));
        stim_q.push_back(insn(16'h0, 32'h8D, x86enc_pkg::EXT_REG, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_MEM), 64'h0, 5'd7, 5'd2,
                              x86enc_pkg::REG_NONE, 2'd0, 32'hFFFF_FF7F));
        stim_q.push_back(insn(16'h0, 32'h03, x86enc_pkg::EXT_REG, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_MEM), 64'h0, 5'd0, 5'd6,
                              x86enc_pkg::REG_NONE, 2'd0, 32'h7FFF_FFFF));
        stim_q.push_back(insn(16'h0, 32'h03, x86enc_pkg::EXT_REG, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_MEM), 64'h0, 5'd0,
                              x86enc_pkg::REG_NONE, 5'd5, 2'd0, 32'h8000_0000));
        // rip-relative, with and without an immediate
        stim_q.push_back(insn(16'h0, 32'h8B, x86enc_pkg::EXT_REG, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_RIP), 64'h0, 5'd9,
                              x86enc_pkg::REG_NONE, x86enc_pkg::REG_NONE, 2'd0, 32'd100));
        stim_q.push_back(insn(16'h6648, 32'hC7, 4'd0, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd2, x86enc_pkg::RM_RIP), 64'hBEEF,
                              x86enc_pkg::REG_NONE, x86enc_pkg::REG_NONE,
                              x86enc_pkg::REG_NONE, 2'd0, 32'hFFFF_FFF0));
        // register added to opcode with 8-byte immediate
        stim_q.push_back(insn(16'h0048, 32'hB8, x86enc_pkg::EXT_RADD, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd4, x86enc_pkg::RM_NONE),
                              64'h0123_4567_89AB_CDEF, x86enc_pkg::REG_NONE, 5'd11,
                              x86enc_pkg::REG_NONE, 2'd0, 32'h0));
        // condition codes: valid, above sixteen, opcode wrap
        stim_q.push_back(insn(16'h0, 32'h0F80, x86enc_pkg::EXT_NONE, 5'd15,
                              kinds_of(2'b00, 3'd3, x86enc_pkg::RM_NONE), 64'hFFFF_FF00,
                              x86enc_pkg::REG_NONE, x86enc_pkg::REG_NONE,
                              x86enc_pkg::REG_NONE, 2'd0, 32'h0));
        stim_q.push_back(insn(16'h0, 32'h0F90, x86enc_pkg::EXT_NONE, 5'd20,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_NONE), 64'h0,
                              x86enc_pkg::REG_NONE, x86enc_pkg::REG_NONE,
                              x86enc_pkg::REG_NONE, 2'd0, 32'h0));
        stim_q.push_back(insn(16'h0, 32'hFFFF_FFFF, x86enc_pkg::EXT_NONE, 5'd5,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_NONE), 64'h0,
                              x86enc_pkg::REG_NONE, x86enc_pkg::REG_NONE,
                              x86enc_pkg::REG_NONE, 2'd0, 32'h0));
        // immediate size code above four, extension code above ten
        stim_q.push_back(insn(16'h0, 32'h05, x86enc_pkg::EXT_NONE, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd6, x86enc_pkg::RM_NONE), '1,
                              x86enc_pkg::REG_NONE, x86enc_pkg::REG_NONE,
                              x86enc_pkg::REG_NONE, 2'd0, 32'h0));
        stim_q.push_back(insn(16'h0, 32'h8B, 4'd13, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_MEM), 64'h0, 5'd3, 5'd3,
                              x86enc_pkg::REG_NONE, 2'd0, 32'd4));
        // register codes above sixteen
        stim_q.push_back(insn(16'h0, 32'h01, x86enc_pkg::EXT_REG, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd0, x86enc_pkg::RM_REG), 64'h0, 5'd20, 5'd25,
                              5'd30, 2'd0, 32'h0));
        // longest encoding: twenty bytes
        stim_q.push_back(insn(16'hF048, 32'h660F_3A0F, 4'd2, x86enc_pkg::CC_NONE,
                              kinds_of(2'b00, 3'd4, x86enc_pkg::RM_MEM),
                              64'hA5A5_5A5A_0F0F_F0F0, x86enc_pkg::REG_NONE,
                              5'd13, 5'd10, 2'd1, 32'h1234_5678));
    endtask

    task drive_insn(insn_t t);
        prefix_and_rex  <= t.prefix_and_rex;
        opcode_word     <= t.opcode_word;
        ext_code        <= t.ext_code;
        cond_code       <= t.cond_code;
        operand_kinds   <= t.operand_kinds;
        immediate_value <= t.immediate_value;
        reg_operand     <= t.reg_operand;
        base_register   <= t.base_register;
        index_register  <= t.index_register;
        scale_log2      <= t.scale_log2;
        displacement    <= t.displacement;
    endtask

    // Code channel: random backpressure, result check on every transfer
    always @(posedge clk)
        code_ready <= keep_busy() || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n && code_valid && code_ready)
            sb.check_byte(code_byte, last_byte);
    end

    // ------------------------------------------------------------------------
    // Item channel driver and end of test
    // ------------------------------------------------------------------------
    initial
    begin
        insn_t cur;
        int    next_idx;
        int    sent;

        next_idx = 0;
        sent     = 0;
        build_directed();
        repeat (RANDOM_ITEMS) stim_q.push_back(rand_insn());

        @(posedge rst_n);
        while (sent < stim_q.size())
        begin
            @(posedge clk);
            if (item_valid && item_ready)
            begin
                sb.note_insn(cur);
                sent++;
            end
            // channel free: present the next template or idle
            if (!item_valid || item_ready)
            begin
                if (next_idx < stim_q.size() &&
                    (keep_busy() || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur = stim_q[next_idx];
                    next_idx++;
                    drive_insn(cur);
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end

        // drain outstanding bytes, then watch for strays
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("timeout: %0d bytes still outstanding", sb.pending_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
